// File: src/lssd_pkg.sv
// Package of constants, codes and types shared by the LIFO stack with search and delete.
`timescale 1ns / 1ps
`default_nettype none
package lssd_pkg;

   localparam int DEPTH = 16;
   localparam int LEVEL_W = $clog2(DEPTH + 1);
   localparam int OPCODE_W = 3;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int LEVEL_OUT_W = 5;

   localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_TOP = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic                      push;
      logic                      pop;
      logic                      del;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

// File: src/lssd_req_if.sv
// Request channel interface carrying an opcode and a value.
`timescale 1ns / 1ps
`default_nettype none
interface lssd_req_if;
   logic                                valid;
   logic                                ready;
   logic [lssd_pkg::OPCODE_W-1:0]       opcode;
   logic signed [lssd_pkg::VALUE_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

// File: src/lssd_rsp_if.sv
// Response channel interface carrying status, data and fill level.
`timescale 1ns / 1ps
`default_nettype none
interface lssd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [lssd_pkg::STATUS_W-1:0]        status;
   logic signed [lssd_pkg::VALUE_W-1:0]  data;
   logic [lssd_pkg::LEVEL_OUT_W-1:0]     level;

   modport source (output valid, output status, output data, output level, input ready);
   modport sink (input valid, input status, input data, input level, output ready);
endinterface
`default_nettype wire

// File: src/lssd_cell.sv
// One stack cell: holds an entry, compares it and shifts towards either neighbour.
`timescale 1ns / 1ps
`default_nettype none
module lssd_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lssd_pkg::cell_cmd_type              cmd,
   input  wire logic signed [lssd_pkg::VALUE_W-1:0] upper_data,
   input  wire logic                                upper_occ,
   input  wire logic signed [lssd_pkg::VALUE_W-1:0] lower_data,
   input  wire logic                                lower_occ,
   input  wire logic                                hit_above,
   output logic signed [lssd_pkg::VALUE_W-1:0]      data,
   output logic                                     occ,
   output logic                                     hit_out
);
   import lssd_pkg::*;

   logic signed [VALUE_W-1:0] data_ff, data_in;
   logic                      occ_ff, occ_in;
   logic                      shift_up;

   // A delete only shifts the matching cell and those below it.
   assign hit_out = hit_above | (occ_ff && (data_ff == cmd.value));
   assign shift_up = cmd.pop | (cmd.del & hit_out);

   always_comb begin
      data_in = data_ff;
      occ_in = occ_ff;
      if (cmd.push) begin
         data_in = upper_data;
         occ_in = upper_occ;
      end else if (shift_up) begin
         data_in = lower_data;
         occ_in = lower_occ;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign data = data_ff;
   assign occ = occ_ff;
endmodule
`default_nettype wire

// File: src/lifo_stack_search_delete_top.sv
// Top level of the LIFO stack with search and delete, built as a row of cells.
//
//   channel   direction   payload                  handshake
//   req_if    in          opcode, value            valid / ready
//   rsp_if    out         status, data, level      valid / ready
//
// Every transaction is handled by the row of cells, which compares all
// entries at once and shifts in the cycle of acceptance; the response is
// registered for the next cycle. A new request is taken in every cycle while
// the response register is empty or being drained. A synchronous reset empties
// the stack. A stalled response holds the request side until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module lifo_stack_search_delete_top (
   input  wire logic clock,
   input  wire logic reset,
   lssd_req_if.sink  req_if,
   lssd_rsp_if.source rsp_if
);
   import lssd_pkg::*;

   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] cell_data [DEPTH];
   logic                      cell_occ [DEPTH];
   logic                      cell_hit [DEPTH];

   logic [LEVEL_W-1:0]        level_ff, level_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [VALUE_W-1:0] data_ff, data_in;
   logic [LEVEL_W-1:0]        rsp_level_ff;
   logic [LEVEL_W+LEVEL_OUT_W-1:0] level_ext;

   logic accept, empty, full, found;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept = req_if.valid && req_if.ready;
   assign empty = (level_ff == '0);
   assign full = (level_ff == LEVEL_W'(DEPTH));
   assign found = cell_hit[DEPTH-1];

   always_comb begin
      cmd.push = accept && (req_if.opcode == OP_PUSH) && !full;
      cmd.pop = accept && (req_if.opcode == OP_POP) && !empty;
      cmd.del = accept && (req_if.opcode == OP_DELETE) && !empty;
      cmd.value = req_if.value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] up_data, low_data;
      logic                      up_occ, low_occ, hit_in;
      if (i == 0) begin : g_first
         assign up_data = req_if.value;
         assign up_occ = 1'b1;
         assign hit_in = 1'b0;
      end else begin : g_inner
         assign up_data = cell_data[i-1];
         assign up_occ = cell_occ[i-1];
         assign hit_in = cell_hit[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign low_data = '0;
         assign low_occ = 1'b0;
      end else begin : g_below
         assign low_data = cell_data[i+1];
         assign low_occ = cell_occ[i+1];
      end
      lssd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .upper_data (up_data),
         .upper_occ  (up_occ),
         .lower_data (low_data),
         .lower_occ  (low_occ),
         .hit_above  (hit_in),
         .data       (cell_data[i]),
         .occ        (cell_occ[i]),
         .hit_out    (cell_hit[i])
      );
   end

   always_comb begin
      level_in = level_ff;
      status_in = ST_OK;
      data_in = '0;
      case (req_if.opcode)
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               level_in = level_ff + LEVEL_W'(1);
            end
         end
         OP_POP, OP_TOP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               data_in = cell_data[0];
               if (req_if.opcode == OP_POP) begin
                  level_in = level_ff - LEVEL_W'(1);
               end
            end
         end
         OP_SEARCH, OP_DELETE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!found) begin
               status_in = ST_NOT_FOUND;
            end else if (req_if.opcode == OP_DELETE) begin
               level_in = level_ff - LEVEL_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         data_ff <= data_in;
         rsp_level_ff <= level_in;
      end
      if (reset) begin
         level_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            level_ff <= level_in;
         end
      end
   end

   // The reported level is the fill count masked to the width of the field.
   assign level_ext = {{LEVEL_OUT_W{1'b0}}, rsp_level_ff};

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = status_ff;
   assign rsp_if.data = data_ff;
   assign rsp_if.level = level_ext[LEVEL_OUT_W-1:0];
endmodule
`default_nettype wire

// File: src/lssd_checker.sv
// Port checker for the LIFO stack with search and delete, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lssd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [lssd_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic signed [lssd_pkg::VALUE_W-1:0] rsp_data,
   input wire logic [lssd_pkg::LEVEL_OUT_W-1:0]    rsp_level
);
   import lssd_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_accept_responds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted request gave no response.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status))
      else $error("Stalled response changed.");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_data == '0))
      else $error("Failed transaction returned data.");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_level == '0))
      else $error("Empty status with non-zero level.");
endmodule

bind lifo_stack_search_delete_top lssd_checker u_lssd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_status (rsp_if.status),
   .rsp_data   (rsp_if.data),
   .rsp_level  (rsp_if.level)
);
`default_nettype wire

// File: bench/lifo_stack_search_delete_top_test.sv
// Self-checking testbench for the LIFO stack with search and delete.
`timescale 1ns / 1ps
module lifo_stack_search_delete_top_test;
   import lssd_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int PRINT_LIMIT = 50;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = OP_DELETE + 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = '1;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [VALUE_W-1:0]  data;
      logic [LEVEL_OUT_W-1:0]     level;
   } stack_result_type;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_type;

   logic clock = 1'b0;
   logic reset;

   lssd_req_if req_ch ();
   lssd_rsp_if rsp_ch ();

   lifo_stack_search_delete_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic signed [VALUE_W-1:0] stack_copy [DEPTH];
   int                        stack_fill = 0;
   stack_result_type          expected_results [$];
   int                        mismatch_count = 0;
   int                        result_count = 0;
   bit                        calm = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the response to one request and updates the copy of the stack.
   function automatic stack_result_type stack_predict(input logic [OPCODE_W-1:0] op,
                                                      input logic signed [VALUE_W-1:0] val);
      stack_result_type res;
      int               pos;
      res.status = ST_OK;
      res.data   = '0;
      pos        = -1;
      case (op)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               stack_copy[stack_fill] = val;
               stack_fill++;
            end
         end
         OP_POP, OP_TOP: begin
            if (stack_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.data = stack_copy[stack_fill-1];
               if (op == OP_POP) stack_fill--;
            end
         end
         OP_SEARCH, OP_DELETE: begin
            if (stack_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               for (int i = stack_fill - 1; i >= 0 && pos < 0; i--) begin
                  if (stack_copy[i] == val) pos = i;
               end
               if (pos < 0) begin
                  res.status = ST_NOT_FOUND;
               end else if (op == OP_DELETE) begin
                  for (int k = pos; k + 1 < stack_fill; k++) stack_copy[k] = stack_copy[k+1];
                  stack_fill--;
               end
            end
         end
         default: begin
         end
      endcase
      res.level = stack_fill[LEVEL_OUT_W-1:0];
      return res;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value(input logic [OPCODE_W-1:0] op);
      int r;
      logic signed [VALUE_W-1:0] pool [8];
      pool = '{32'sh0, -32'sd1, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
               32'sh5555_5555, 32'shAAAA_AAAA, 32'sd7};
      r = $urandom_range(99);
      if ((op == OP_SEARCH || op == OP_DELETE) && stack_fill > 0 && r < 60)
         return stack_copy[$urandom_range(stack_fill - 1)];
      if (r < 75) return pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_opcode(input traffic_mix_type mix);
      int r;
      int lim [5];
      r = $urandom_range(99);
      case (mix)
         MIX_GROW:   lim = '{55, 65, 73, 85, 97};
         MIX_SHRINK: lim = '{20, 55, 65, 75, 97};
         default:    lim = '{36, 56, 66, 80, 97};
      endcase
      if (r < lim[0]) return OP_PUSH;
      if (r < lim[1]) return OP_POP;
      if (r < lim[2]) return OP_TOP;
      if (r < lim[3]) return OP_SEARCH;
      if (r < lim[4]) return OP_DELETE;
      return OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at response %0d, %s: got %h, expected %h",
                  result_count, what, got, want);
      mismatch_count++;
   endtask

   // Called at a rising edge; returns at the edge that accepts the transaction.
   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic signed [VALUE_W-1:0] val);
      while (!calm && $urandom_range(99) < 34) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.value  <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_results.push_back(stack_predict(op, val));
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_stack();
      send_request(OP_POP, 32'sd0);
      send_request(OP_TOP, -32'sd1);
      send_request(OP_SEARCH, 32'sd0);
      send_request(OP_DELETE, 32'sh8000_0000);
      send_request(OP_SPARE_LO, 32'sh7FFF_FFFF);
   endtask

   task automatic test_fill_and_overflow();
      logic signed [VALUE_W-1:0] fill_values [8];
      fill_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                      32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1};
      foreach (fill_values[i]) send_request(OP_PUSH, fill_values[i]);
      for (int i = 0; i < DEPTH - 8; i++) send_request(OP_PUSH, $urandom);
      send_request(OP_PUSH, 32'sd42);
   endtask

   task automatic test_search_and_delete();
      send_request(OP_SEARCH, 32'sh7FFF_FFFF);
      send_request(OP_SEARCH, 32'sd2);
      send_request(OP_DELETE, 32'sh8000_0000);
      send_request(OP_DELETE, 32'sd2);
      send_request(OP_TOP, 32'sd0);
      send_request(OP_POP, 32'sd0);
      send_request(OP_SPARE_HI, -32'sd1);
   endtask

   task automatic test_random_traffic(input traffic_mix_type mix, input int count);
      logic [OPCODE_W-1:0] op;
      int                  sent;
      sent = 0;
      while (sent < count) begin
         op = pick_opcode(mix);
         send_request(op, pick_value(op));
         if (op <= OP_DELETE) sent++;
      end
   endtask

   task automatic test_quiet_stretch();
      calm = 1'b1;
      test_random_traffic(MIX_GROW, 200);
      calm = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      test_random_traffic(MIX_EVEN, 100);
      wait_for_drain();
      test_random_traffic(MIX_EVEN, 100);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
      end
   end

   always @(posedge clock) begin : check_response
      stack_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_ch.data, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", VALUE_W'(rsp_ch.status), VALUE_W'(want.status));
            if (rsp_ch.data !== want.data)
               report_mismatch("data", rsp_ch.data, want.data);
            if (rsp_ch.level !== want.level)
               report_mismatch("level", VALUE_W'(rsp_ch.level), VALUE_W'(want.level));
         end
         result_count++;
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("lifo_stack_search_delete_top regression: fail");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= OP_PUSH;
      req_ch.value  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stack();
      test_fill_and_overflow();
      test_search_and_delete();
      test_random_traffic(MIX_GROW, 200);
      test_random_traffic(MIX_SHRINK, 200);
      test_random_traffic(MIX_EVEN, 200);
      test_quiet_stretch();
      test_pause_until_drained();
      test_random_traffic(MIX_SHRINK, 200);
      test_random_traffic(MIX_EVEN, 200);
      test_random_traffic(MIX_GROW, 200);

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("lifo_stack_search_delete_top regression: pass");
      else
         $display("lifo_stack_search_delete_top regression: fail");
      $finish;
   end
endmodule
